/* rtl/anpg_pkg.sv */
// ----------------------------------------------------------------------------
// anpg_pkg - Annex-B NAL parser gate shared types
// Action codes, NAL type codes and field widths for the parser gate.
// ----------------------------------------------------------------------------
`default_nettype none

package anpg_pkg;

    localparam int LEN_W = 20;

    typedef enum logic [2:0] {
        ACT_IGNORED     = 3'd0,
        ACT_REJECTED    = 3'd1,
        ACT_STORED      = 3'd2,
        ACT_FORWARD     = 3'd3,
        ACT_BOOTSTRAP   = 3'd4,
        ACT_WAITING     = 3'd5,
        ACT_IDR_NO_SINK = 3'd6
    } action_t;

    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    localparam logic [7:0] PROF_BASE     = 8'd66;
    localparam logic [7:0] PROF_MAIN     = 8'd77;
    localparam logic [7:0] PROF_EXT      = 8'd88;
    localparam logic [7:0] PROF_HIGH     = 8'd100;
    localparam logic [7:0] PROF_HIGH10   = 8'd110;
    localparam logic [7:0] PROF_HIGH422  = 8'd122;
    localparam logic [7:0] PROF_HIGH444  = 8'd244;

    localparam int SPS_MIN_LEN   = 4;
    localparam int SPS_MAX_LEN   = 128;
    localparam int PPS_MIN_LEN   = 2;
    localparam int PPS_MAX_LEN   = 96;
    localparam int IDR_MIN_LEN   = 16;
    localparam int SLICE_MIN_LEN = 4;

    typedef struct packed {
        action_t    action;
        logic [LEN_W-1:0] nal_length;
        logic [1:0] ref_level;
        logic [4:0] nal_type;
    } desc_t;

endpackage

`default_nettype wire

/* rtl/annexb_nal_parser_gate.sv */
// ----------------------------------------------------------------------------
// annexb_nal_parser_gate - Annex-B NAL unit parser with sink bootstrap gating
// Splits a byte stream at start codes, strips trailing zeros and issues one
// descriptor word (type, ref level, length, action) per closed NAL unit.
// ----------------------------------------------------------------------------
// channel  dir  tdata                              tuser
// s_*      in   [7:0] data_byte                    [0] kind (1 = new session)
// m_*      out  [4:0] type [6:5] ref [26:7] length  -
//               [29:27] action
// cfg_*    in   cfg_wdata = forwarding_enabled, written when cfg_we is high
//
// One word per cycle: input register, one pass of compare/count logic, result
// register. m_tvalid is registered and rises after the held byte advances.
// A held result stalls the input stage only while m_tready is low.
// rst_n clears all parser state, gating flags and the configuration bit.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_parser_gate
    import anpg_pkg::*;
#(
    parameter int MAX_UNIT_BYTES = 524288
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [4:0] nal_type, [6:5] ref_level,
                                        // [26:7] nal_length, [29:27] action
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_UNIT_BYTES + 2);
    localparam logic [CNT_W-1:0] CAP  = CNT_W'(MAX_UNIT_BYTES + 1);
    localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_UNIT_BYTES);

    logic             fwd_en_reg;
    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [7:0]       in_byte_reg;

    logic             synced_reg, synced_next;
    logic [CNT_W-1:0] zero_run_reg, zero_run_next;
    logic [CNT_W-1:0] unit_count_reg, unit_count_next;
    logic [7:0]       header_reg, header_next;
    logic [7:0]       second_reg, second_next;
    logic             sps_seen_reg, sps_seen_next;
    logic             pps_seen_reg, pps_seen_next;
    logic             sink_reg, sink_next;
    logic             live_reg, live_next;

    logic             out_valid_reg, out_valid_next;
    desc_t            out_reg;

    logic             advance;
    logic             emit;
    desc_t            desc;

    action_t          dec_act;
    logic             dec_sps, dec_pps, dec_live;
    logic [4:0]       hdr_type;
    logic             refd;
    logic             prof_ok;
    logic [CNT_W:0]   pos_b;
    logic [CNT_W:0]   total;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

    // unit decision
    assign hdr_type = header_reg[4:0];
    assign refd     = |header_reg[6:5];

    always_comb
    begin
        prof_ok = second_reg inside {PROF_BASE, PROF_MAIN, PROF_EXT, PROF_HIGH,
                                     PROF_HIGH10, PROF_HIGH422, PROF_HIGH444};
    end

    always_comb
    begin
        dec_act  = ACT_IGNORED;
        dec_sps  = 1'b0;
        dec_pps  = 1'b0;
        dec_live = 1'b0;
        if (unit_count_reg > MAXV || header_reg[7])
        begin
            dec_act = ACT_REJECTED;
        end
        else
        begin
            case (hdr_type)
                NAL_SPS:
                begin
                    if (unit_count_reg < CNT_W'(SPS_MIN_LEN) ||
                        unit_count_reg > CNT_W'(SPS_MAX_LEN) || !refd || !prof_ok)
                    begin
                        dec_act = ACT_REJECTED;
                    end
                    else
                    begin
                        dec_sps = 1'b1;
                        dec_act = (fwd_en_reg && live_reg) ? ACT_FORWARD : ACT_STORED;
                    end
                end
                NAL_PPS:
                begin
                    if (unit_count_reg < CNT_W'(PPS_MIN_LEN) ||
                        unit_count_reg > CNT_W'(PPS_MAX_LEN) || !refd)
                    begin
                        dec_act = ACT_REJECTED;
                    end
                    else
                    begin
                        dec_pps = 1'b1;
                        dec_act = (fwd_en_reg && live_reg) ? ACT_FORWARD : ACT_STORED;
                    end
                end
                NAL_IDR:
                begin
                    if (!refd || unit_count_reg < CNT_W'(IDR_MIN_LEN))
                        dec_act = ACT_REJECTED;
                    else if (!fwd_en_reg)
                        dec_act = ACT_IGNORED;
                    else if (!sink_reg)
                        dec_act = ACT_IDR_NO_SINK;
                    else if (live_reg)
                        dec_act = ACT_FORWARD;
                    else if (sps_seen_reg && pps_seen_reg)
                    begin
                        dec_live = 1'b1;
                        dec_act  = ACT_BOOTSTRAP;
                    end
                    else
                        dec_act = ACT_WAITING;
                end
                NAL_SLICE:
                begin
                    if (!refd || unit_count_reg < CNT_W'(SLICE_MIN_LEN))
                        dec_act = ACT_REJECTED;
                    else if (!fwd_en_reg || !sink_reg)
                        dec_act = ACT_IGNORED;
                    else
                        dec_act = live_reg ? ACT_FORWARD : ACT_WAITING;
                end
                default:
                begin
                    dec_act = ACT_IGNORED;
                end
            endcase
        end
    end

    // parser state update
    assign pos_b = {1'b0, unit_count_reg} + {1'b0, zero_run_reg};
    assign total = pos_b + 1'b1;

    always_comb
    begin
        synced_next     = synced_reg;
        zero_run_next   = zero_run_reg;
        unit_count_next = unit_count_reg;
        header_next     = header_reg;
        second_next     = second_reg;
        sps_seen_next   = sps_seen_reg;
        pps_seen_next   = pps_seen_reg;
        sink_next       = sink_reg;
        live_next       = live_reg;
        emit            = 1'b0;

        desc.nal_type   = header_reg[4:0];
        desc.ref_level  = header_reg[6:5];
        desc.nal_length = LEN_W'(unit_count_reg);
        desc.action     = dec_act;

        if (advance)
        begin
            if (in_kind_reg)
            begin
                sink_next = 1'b1;
                live_next = 1'b0;
            end
            else if (in_byte_reg == 8'h00)
            begin
                if (zero_run_reg < CAP)
                    zero_run_next = zero_run_reg + 1'b1;
            end
            else if (in_byte_reg == 8'h01 && zero_run_reg >= CNT_W'(2))
            begin
                if (synced_reg && unit_count_reg != '0)
                begin
                    emit = 1'b1;
                    if (dec_sps)
                        sps_seen_next = 1'b1;
                    if (dec_pps)
                        pps_seen_next = 1'b1;
                    if (dec_live)
                        live_next = 1'b1;
                end
                synced_next     = 1'b1;
                unit_count_next = '0;
                zero_run_next   = '0;
                header_next     = 8'h00;
                second_next     = 8'h00;
            end
            else
            begin
                if (synced_reg)
                begin
                    if (unit_count_reg == '0)
                        header_next = (zero_run_reg != '0) ? 8'h00 : in_byte_reg;
                    if (unit_count_reg <= CNT_W'(1))
                    begin
                        if (pos_b == (CNT_W+1)'(1))
                            second_next = in_byte_reg;
                        else if (pos_b > (CNT_W+1)'(1))
                            second_next = 8'h00;
                    end
                    unit_count_next = (total > {1'b0, CAP}) ? CAP : total[CNT_W-1:0];
                end
                zero_run_next = '0;
            end
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg     <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            synced_reg     <= 1'b0;
            zero_run_reg   <= '0;
            unit_count_reg <= '0;
            header_reg     <= 8'h00;
            second_reg     <= 8'h00;
            sps_seen_reg   <= 1'b0;
            pps_seen_reg   <= 1'b0;
            sink_reg       <= 1'b0;
            live_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fwd_en_reg <= cfg_wdata;
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            out_valid_reg  <= out_valid_next;
            synced_reg     <= synced_next;
            zero_run_reg   <= zero_run_next;
            unit_count_reg <= unit_count_next;
            header_reg     <= header_next;
            second_reg     <= second_next;
            sps_seen_reg   <= sps_seen_next;
            pps_seen_reg   <= pps_seen_next;
            sink_reg       <= sink_next;
            live_reg       <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance && emit)
            out_reg <= desc;
    end

`ifndef SYNTHESIS
    a_live_by_bootstrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(live_reg) |-> (out_valid_reg && out_reg.action == ACT_BOOTSTRAP))
        else $error("stream went live without a bootstrap word");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.nal_length != '0 || CNT_W > LEN_W))
        else $error("empty unit produced a word");

    a_counts_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (zero_run_reg <= CAP) && (unit_count_reg <= CAP))
        else $error("counter above saturation limit");

    a_params_stick: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sps_seen_reg) || $fell(pps_seen_reg) |-> 1'b0)
        else $error("parameter set flag cleared");
`endif

endmodule

`default_nettype wire
